>>> rtl/fjrp_pkg.sv
// ----------------------------------------------------------------------------
// fjrp_pkg
// Shared types and constants of the flat JSON record parser: byte classes,
// parse phases, result kinds, fault codes and the queue entry layout.
// ----------------------------------------------------------------------------
package fjrp_pkg;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
   localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
   localparam logic [7:0] CH_QUOTE  = 8'h22;  // "
   localparam logic [7:0] CH_COLON  = 8'h3A;  // :
   localparam logic [7:0] CH_COMMA  = 8'h2C;  // ,
   localparam logic [7:0] CH_RBRACE = 8'h7D;  // }
   localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]

   typedef enum logic [3:0] {
      CLS_LBRACK,
      CLS_LBRACE,
      CLS_QUOTE,
      CLS_COLON,
      CLS_COMMA,
      CLS_RBRACE,
      CLS_RBRACK,
      CLS_OTHER,
      CLS_END
   } char_class_type;

   typedef enum logic [3:0] {
      PH_INIT     = 4'd0,
      PH_OBJ_INIT = 4'd1,
      PH_ARR_INIT = 4'd2,
      PH_KEY_OPEN = 4'd3,
      PH_KEY_READ = 4'd4,
      PH_KEY_END  = 4'd5,
      PH_COLON    = 4'd6,
      PH_VAL_OPEN = 4'd7,
      PH_VAL_READ = 4'd8,
      PH_VAL_END  = 4'd9,
      PH_NEXT     = 4'd10,
      PH_DONE     = 4'd11
   } phase_type;

   typedef enum logic [2:0] {
      K_NONE    = 3'd0,
      K_KEY     = 3'd1,
      K_VAL     = 3'd2,
      K_KEYEND  = 3'd3,
      K_PAIREND = 3'd4,
      K_DONE    = 3'd5,
      K_ERR     = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      F_NONE       = 3'd0,
      F_NO_ARRAY   = 3'd1,
      F_STRUCTURE  = 3'd2,
      F_NO_VALUE   = 3'd3,
      F_NO_OBJECT  = 3'd4,
      F_AFTER_DONE = 3'd5,
      F_EARLY_END  = 3'd6
   } fault_type;

   typedef enum logic {
      BR_ARR = 1'b0,
      BR_OBJ = 1'b1
   } bracket_type;

   typedef struct packed {
      char_class_type cls;
      logic [7:0]     char_code;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/flat_json_record_parser.sv
// ----------------------------------------------------------------------------
// flat_json_record_parser
// Checks a byte stream as a JSON array of flat string-to-string objects and
// emits tagged key/value bytes, key-end and pair-end marks and a record index.
// ----------------------------------------------------------------------------
// One request (a byte, or an end-of-input mark) gives exactly one response.
// The block sustains one request per clock while rsp_stall is low: the front
// classifies each byte and pushes it into a two-entry queue, and the back
// parser takes one queued byte per cycle into the response register, so a
// request is held in a queue entry and then in the response register. When
// rsp_stall holds the response register the queue fills, and req_stall rises
// once both entries are occupied. The first fault latches rsp_fault_code;
// every later request answers with kind "nothing" and that code until reset.
// The record index counts commas at array level, saturates at the top of the
// RECORD_INDEX_BITS counter and is shown as its low 32 bits on every response.
module flat_json_record_parser #(
   parameter int RECORD_INDEX_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_flag,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_out_char,
   output logic [31:0] rsp_row_index,
   output logic [2:0]  rsp_fault_code
);

   fjrp_pkg::queue_status_type q_status;
   fjrp_pkg::item_type         push_item;
   fjrp_pkg::item_type         head_item;
   logic                       push;
   logic                       pop;

   // classify the byte and push it while the queue has room
   fjrp_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_end_flag  (req_end_flag),
      .q_status      (q_status),
      .push          (push),
      .push_item     (push_item)
   );

   // decouple the request side from the parser
   fjrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   // advance the parse one byte per cycle unless stalled and hold the response
   fjrp_back #(
      .RECORD_INDEX_BITS (RECORD_INDEX_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_item      (head_item),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_char   (rsp_out_char),
      .rsp_row_index  (rsp_row_index),
      .rsp_fault_code (rsp_fault_code)
   );

endmodule

>>> rtl/fjrp_front.sv
// ----------------------------------------------------------------------------
// fjrp_front
// Request side: classifies each byte and pushes it into the queue while
// the queue has room.
// ----------------------------------------------------------------------------
module fjrp_front (
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_char_code,
   input  logic                       req_end_flag,
   input  fjrp_pkg::queue_status_type q_status,
   output logic                       push,
   output fjrp_pkg::item_type         push_item
);

   fjrp_pkg::char_class_type cls;

   always_comb begin
      cls = fjrp_pkg::CLS_OTHER;
      if (req_end_flag) begin
         cls = fjrp_pkg::CLS_END;
      end else begin
         case (req_char_code)
            fjrp_pkg::CH_LBRACK: cls = fjrp_pkg::CLS_LBRACK;
            fjrp_pkg::CH_LBRACE: cls = fjrp_pkg::CLS_LBRACE;
            fjrp_pkg::CH_QUOTE:  cls = fjrp_pkg::CLS_QUOTE;
            fjrp_pkg::CH_COLON:  cls = fjrp_pkg::CLS_COLON;
            fjrp_pkg::CH_COMMA:  cls = fjrp_pkg::CLS_COMMA;
            fjrp_pkg::CH_RBRACE: cls = fjrp_pkg::CLS_RBRACE;
            fjrp_pkg::CH_RBRACK: cls = fjrp_pkg::CLS_RBRACK;
            default:             cls = fjrp_pkg::CLS_OTHER;
         endcase
      end
   end

   assign req_stall           = q_status.full;
   assign push                = req_valid & ~q_status.full;
   assign push_item.cls       = cls;
   assign push_item.char_code = req_char_code;

endmodule

>>> rtl/fjrp_queue.sv
// ----------------------------------------------------------------------------
// fjrp_queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module fjrp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  fjrp_pkg::item_type         push_item,
   input  logic                       pop,
   output fjrp_pkg::item_type         head_item,
   output fjrp_pkg::queue_status_type q_status
);

   fjrp_pkg::item_type                         mem_ff [fjrp_pkg::QUEUE_DEPTH];
   logic [fjrp_pkg::QUEUE_PTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [fjrp_pkg::QUEUE_PTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [fjrp_pkg::QUEUE_CNT_BITS-1:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item      = mem_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == fjrp_pkg::QUEUE_CNT_BITS'(fjrp_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

>>> rtl/fjrp_back.sv
// ----------------------------------------------------------------------------
// fjrp_back
// Parser state machine: takes one queued byte per cycle unless stalled and
// updates phase, bracket stack, record count, fault and response register.
// ----------------------------------------------------------------------------
module fjrp_back #(
   parameter int RECORD_INDEX_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fjrp_pkg::item_type         head_item,
   input  fjrp_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_kind,
   output logic [7:0]                 rsp_out_char,
   output logic [31:0]                rsp_row_index,
   output logic [2:0]                 rsp_fault_code
);

   fjrp_pkg::phase_type          phase_ff, phase_in;
   logic [1:0]                   depth_ff, depth_in;
   logic [RECORD_INDEX_BITS-1:0] count_ff, count_in;
   fjrp_pkg::fault_type          fault_ff, fault_in;
   fjrp_pkg::bracket_type        bracket_ff [2];

   logic                         valid_ff, valid_in;
   fjrp_pkg::kind_type           kind_ff, kind_in;
   logic [7:0]                   char_ff, char_in;
   logic [31:0]                  row_ff, row_in;

   logic                         wr_en;
   logic                         wr_idx;
   fjrp_pkg::bracket_type        wr_kind;

   always_comb begin
      logic                  do_push;
      logic                  do_pop;
      fjrp_pkg::bracket_type push_kind;
      fjrp_pkg::phase_type   push_next;
      fjrp_pkg::bracket_type top;
      logic [1:0]            nd;
      logic [63:0]           count_wide;

      do_push   = 1'b0;
      do_pop    = 1'b0;
      push_kind = fjrp_pkg::BR_ARR;
      push_next = fjrp_pkg::PH_ARR_INIT;
      top       = bracket_ff[1'(depth_ff - 2'd1)];
      nd        = '0;

      phase_in = phase_ff;
      depth_in = depth_ff;
      count_in = count_ff;
      fault_in = fault_ff;
      kind_in  = fjrp_pkg::K_NONE;
      char_in  = '0;
      wr_en    = 1'b0;
      wr_idx   = depth_ff[0];
      wr_kind  = fjrp_pkg::BR_ARR;

      pop = ~q_status.empty & (~valid_ff | ~rsp_stall);

      if (pop && fault_ff == fjrp_pkg::F_NONE) begin
         if (head_item.cls == fjrp_pkg::CLS_END) begin
            if (depth_ff == 2'd0 || phase_ff == fjrp_pkg::PH_DONE) begin
               phase_in = fjrp_pkg::PH_DONE;
               kind_in  = fjrp_pkg::K_DONE;
            end else begin
               fault_in = fjrp_pkg::F_EARLY_END;
               kind_in  = fjrp_pkg::K_ERR;
            end
         end else begin
            case (phase_ff)
               fjrp_pkg::PH_INIT: begin
                  count_in = '0;
                  if (head_item.cls == fjrp_pkg::CLS_LBRACK) begin
                     do_push   = 1'b1;
                     push_kind = fjrp_pkg::BR_ARR;
                     push_next = fjrp_pkg::PH_ARR_INIT;
                  end else begin
                     fault_in = fjrp_pkg::F_NO_ARRAY;
                     kind_in  = fjrp_pkg::K_ERR;
                  end
               end
               fjrp_pkg::PH_OBJ_INIT: begin
                  if (head_item.cls == fjrp_pkg::CLS_QUOTE) begin
                     phase_in = fjrp_pkg::PH_KEY_OPEN;
                  end else if (head_item.cls == fjrp_pkg::CLS_RBRACE) begin
                     do_pop = 1'b1;
                  end else begin
                     fault_in = fjrp_pkg::F_STRUCTURE;
                     kind_in  = fjrp_pkg::K_ERR;
                  end
               end
               fjrp_pkg::PH_ARR_INIT: begin
                  if (head_item.cls == fjrp_pkg::CLS_LBRACE) begin
                     do_push   = 1'b1;
                     push_kind = fjrp_pkg::BR_OBJ;
                     push_next = fjrp_pkg::PH_OBJ_INIT;
                  end else if (head_item.cls == fjrp_pkg::CLS_RBRACK) begin
                     depth_in = 2'd0;
                     phase_in = fjrp_pkg::PH_DONE;
                  end else begin
                     fault_in = fjrp_pkg::F_NO_OBJECT;
                     kind_in  = fjrp_pkg::K_ERR;
                  end
               end
               fjrp_pkg::PH_KEY_OPEN, fjrp_pkg::PH_KEY_READ: begin
                  if (head_item.cls == fjrp_pkg::CLS_QUOTE) begin
                     phase_in = fjrp_pkg::PH_KEY_END;
                     kind_in  = fjrp_pkg::K_KEYEND;
                  end else begin
                     phase_in = fjrp_pkg::PH_KEY_READ;
                     kind_in  = fjrp_pkg::K_KEY;
                     char_in  = head_item.char_code;
                  end
               end
               fjrp_pkg::PH_VAL_OPEN, fjrp_pkg::PH_VAL_READ: begin
                  if (head_item.cls == fjrp_pkg::CLS_QUOTE) begin
                     phase_in = fjrp_pkg::PH_VAL_END;
                     kind_in  = fjrp_pkg::K_PAIREND;
                  end else begin
                     phase_in = fjrp_pkg::PH_VAL_READ;
                     kind_in  = fjrp_pkg::K_VAL;
                     char_in  = head_item.char_code;
                  end
               end
               fjrp_pkg::PH_KEY_END: begin
                  if (head_item.cls == fjrp_pkg::CLS_COLON) begin
                     phase_in = fjrp_pkg::PH_COLON;
                  end else begin
                     fault_in = fjrp_pkg::F_STRUCTURE;
                     kind_in  = fjrp_pkg::K_ERR;
                  end
               end
               fjrp_pkg::PH_COLON: begin
                  if (head_item.cls == fjrp_pkg::CLS_QUOTE) begin
                     phase_in = fjrp_pkg::PH_VAL_OPEN;
                  end else begin
                     fault_in = fjrp_pkg::F_NO_VALUE;
                     kind_in  = fjrp_pkg::K_ERR;
                  end
               end
               fjrp_pkg::PH_VAL_END, fjrp_pkg::PH_NEXT: begin
                  if (depth_ff == 2'd0) begin
                     fault_in = fjrp_pkg::F_STRUCTURE;
                     kind_in  = fjrp_pkg::K_ERR;
                  end else if (head_item.cls == fjrp_pkg::CLS_COMMA &&
                               top == fjrp_pkg::BR_ARR) begin
                     if (~&count_ff) begin
                        count_in = count_ff + RECORD_INDEX_BITS'(1);
                     end
                     phase_in = fjrp_pkg::PH_ARR_INIT;
                  end else if (head_item.cls == fjrp_pkg::CLS_COMMA) begin
                     phase_in = fjrp_pkg::PH_OBJ_INIT;
                  end else if (head_item.cls inside {fjrp_pkg::CLS_RBRACE,
                                                     fjrp_pkg::CLS_RBRACK}) begin
                     do_pop = 1'b1;
                  end else begin
                     fault_in = fjrp_pkg::F_STRUCTURE;
                     kind_in  = fjrp_pkg::K_ERR;
                  end
               end
               fjrp_pkg::PH_DONE: begin
                  if (head_item.cls != fjrp_pkg::CLS_RBRACK) begin
                     fault_in = fjrp_pkg::F_AFTER_DONE;
                     kind_in  = fjrp_pkg::K_ERR;
                  end
               end
               default: begin
                  fault_in = fjrp_pkg::F_STRUCTURE;
                  kind_in  = fjrp_pkg::K_ERR;
               end
            endcase

            // push a bracket, overflow at two levels
            if (do_push) begin
               if (depth_ff >= 2'd2) begin
                  fault_in = fjrp_pkg::F_STRUCTURE;
                  kind_in  = fjrp_pkg::K_ERR;
               end else begin
                  wr_en    = 1'b1;
                  wr_kind  = push_kind;
                  depth_in = depth_ff + 2'd1;
                  phase_in = push_next;
               end
            end

            // pop one level without checking its type
            if (do_pop) begin
               nd       = (depth_ff != 2'd0) ? depth_ff - 2'd1 : depth_ff;
               depth_in = nd;
               if (nd == 2'd0) begin
                  phase_in = fjrp_pkg::PH_DONE;
               end else if (bracket_ff[1'(nd - 2'd1)] == fjrp_pkg::BR_ARR) begin
                  phase_in = fjrp_pkg::PH_NEXT;
               end else begin
                  fault_in = fjrp_pkg::F_STRUCTURE;
                  kind_in  = fjrp_pkg::K_ERR;
               end
            end
         end
      end

      count_wide = 64'(count_in);
      row_in     = count_wide[31:0];
      valid_in   = pop | (valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fjrp_pkg::PH_INIT;
         depth_ff <= '0;
         count_ff <= '0;
         fault_ff <= fjrp_pkg::F_NONE;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         depth_ff <= depth_in;
         count_ff <= count_in;
         fault_ff <= fault_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bracket_ff[wr_idx] <= wr_kind;
      end
      if (pop) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
         row_ff  <= row_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_row_index  = row_ff;
   assign rsp_fault_code = fault_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff != 2'd3)
      else $error("bracket stack deeper than two");

   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      (fault_ff != fjrp_pkg::F_NONE) |=> $stable(fault_ff))
      else $error("latched fault changed");

   a_err_has_code: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == fjrp_pkg::K_ERR) |-> fault_ff != fjrp_pkg::F_NONE)
      else $error("error response without fault code");

   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |-> !pop)
      else $error("response overwritten while stalled");

endmodule
